// ===== rtl/wpb_pkg.sv =====
// Shared constants, types and control structs of the windowed power bank.
package wpb_pkg;

    // Field widths.
    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 16;
    localparam int POWER_W  = 42;

    // Bank geometry.
    localparam int WINDOW   = 2048;
    localparam int CHANNELS = 10;

    // Derived widths.
    localparam int SQ_W     = 31;
    localparam int MAG_W    = SAMPLE_W + 1;
    localparam int PROD_W   = 2 * MAG_W;
    localparam int POS_W    = $clog2(WINDOW);
    localparam int SUM_W    = SQ_W + $clog2(WINDOW);
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH    = CHANNELS * WINDOW;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int EXT_W    = (SUM_W > POWER_W) ? SUM_W : POWER_W;

    // Channel numbers below this limit are valid.
    localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);

    // Largest value the power output can show.
    localparam logic [POWER_W-1:0] POWER_MAX = '1;

    typedef logic [SQ_W-1:0]     t_sq;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [CH_IDX_W-1:0] t_ch_idx;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [POWER_W-1:0]  t_power;

    // Ring read request, issued when a word is accepted.
    typedef struct packed {
        logic    en;
        t_ch_idx ch;
    } t_ring_req;

    // Ring writeback of the new square.
    typedef struct packed {
        logic en;
        t_sq  sq;
    } t_ring_wr;

    // Running sum update.
    typedef struct packed {
        logic    en;
        t_ch_idx ch;
        t_sq     sq;
        t_sq     old_sq;
    } t_sum_upd;

    // Result of the strongest-channel search.
    typedef struct packed {
        logic            any;
        logic [CH_W-1:0] idx;
    } t_best;

endpackage

// ===== rtl/wpb_in_if.sv =====
// Input channel interface: one sample word with its channel number.
interface wpb_in_if;
    import wpb_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

// ===== rtl/wpb_out_if.sv =====
// Output channel interface: channel power and strongest-channel result word.
interface wpb_out_if;
    import wpb_pkg::*;

    logic               valid;
    logic               ready;
    logic [POWER_W-1:0] channel_power;
    logic [CH_W-1:0]    strongest_channel;
    logic               any_power;

    modport source (output valid, output channel_power, output strongest_channel,
                    output any_power, input ready);
    modport sink   (input valid, input channel_power, input strongest_channel,
                    input any_power, output ready);
endinterface

// ===== rtl/wpb_ring.sv =====
// Square ring memory with per-channel slot pointers and fill flags.
module wpb_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wpb_pkg::t_ring_req i_rd,
    input  wpb_pkg::t_ring_wr  i_wr,
    output wpb_pkg::t_sq       o_old_sq
);
    import wpb_pkg::*;

    t_sq   mem [DEPTH];
    t_pos  r_pos  [CHANNELS];
    logic  r_full [CHANNELS];
    t_sq   r_rd_data;
    logic  r_rd_full;
    t_addr r_addr;

    t_pos  rd_pos;
    t_pos  n_pos;
    logic  wrap;
    t_addr rd_addr;

    // Oldest slot of the requested channel and the pointer after it.
    always_comb begin
        rd_pos  = r_pos[i_rd.ch];
        wrap    = (rd_pos == POS_W'(WINDOW - 1));
        n_pos   = wrap ? '0 : rd_pos + POS_W'(1);
        rd_addr = ADDR_W'(i_rd.ch) * ADDR_W'(WINDOW) + ADDR_W'(rd_pos);
    end

    // Pointers advance on each read; a channel is full once its ring wraps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_pos[i]  <= '0;
                r_full[i] <= 1'b0;
            end
        end else if (i_rd.en) begin
            r_pos[i_rd.ch] <= n_pos;
            if (wrap) begin
                r_full[i_rd.ch] <= 1'b1;
            end
        end
    end

    // Memory read at accept, writeback of the same slot one stage later.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[r_addr] <= i_wr.sq;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_full <= r_full[i_rd.ch];
            r_addr    <= rd_addr;
        end
    end

    // A slot that was never written holds a zero square.
    assign o_old_sq = r_rd_full ? r_rd_data : '0;

endmodule

// ===== rtl/wpb_sums.sv =====
// Per-channel running window sums with add-new, subtract-old update.
module wpb_sums (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wpb_pkg::t_sum_upd i_upd,
    output wpb_pkg::t_sum     o_upd_sum,
    output wpb_pkg::t_sum     o_sums [wpb_pkg::CHANNELS]
);
    import wpb_pkg::*;

    t_sum r_sum [CHANNELS];
    t_sum n_sum;

    // The leaving square is part of the sum, so the result never underflows.
    assign n_sum = r_sum[i_upd.ch] + SUM_W'(i_upd.sq) - SUM_W'(i_upd.old_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_sum[i] <= '0;
            end
        end else if (i_upd.en) begin
            r_sum[i_upd.ch] <= n_sum;
        end
    end

    assign o_upd_sum = n_sum;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            o_sums[i] = r_sum[i];
        end
    end

endmodule

// ===== rtl/wpb_max.sv =====
// Strongest-channel search: a balanced compare tree over all window sums.
module wpb_max (
    input  wpb_pkg::t_sum  i_sums [wpb_pkg::CHANNELS],
    output wpb_pkg::t_best o_best
);
    import wpb_pkg::*;

    localparam int LEAVES = 1 << $clog2(CHANNELS);
    localparam int NODES  = 2 * LEAVES - 1;

    typedef struct packed {
        t_sum            val;
        logic [CH_W-1:0] idx;
    } t_node;

    t_node node [NODES];

    // Leaves hold the sums; unused leaves are zero and sit to the right.
    // On a tie the left entry wins, which keeps the lowest channel index.
    always_comb begin
        for (int i = 0; i < LEAVES; i++) begin
            if (i < CHANNELS) begin
                node[LEAVES - 1 + i].val = i_sums[i];
            end else begin
                node[LEAVES - 1 + i].val = '0;
            end
            node[LEAVES - 1 + i].idx = CH_W'(i);
        end
        for (int n = LEAVES - 2; n >= 0; n--) begin
            if (node[2 * n + 1].val >= node[2 * n + 2].val) begin
                node[n] = node[2 * n + 1];
            end else begin
                node[n] = node[2 * n + 2];
            end
        end
    end

    // With all sums zero the tree already yields channel zero.
    assign o_best.any = (node[0].val != '0);
    assign o_best.idx = node[0].idx;

endmodule

// ===== rtl/windowed_power_bank_with_max_core.sv =====
// Top level of the windowed power bank: handshake pipeline around ring and sums.
// Each accepted word carries a channel and a signed sample; the block squares the
// sample, adds it to that channel's window sum of the last WINDOW squares, drops the
// square leaving the window, and returns the channel's power (saturated to 42 bits)
// with the lowest-index channel holding the greatest positive power and a flag telling
// whether any power is positive. A word with a channel number out of range changes
// nothing and reports zero power. One word is taken every cycle while the output is not
// stalled; a result is offered once its word has passed stage 1, stage 2 and the output
// register. The ring memory is read once when a word is accepted and written back when
// the word leaves stage 1. No clearing pass follows reset: a per-channel fill flag makes
// unwritten ring slots read as zero, so the block accepts words from the first cycle out
// of reset.
module windowed_power_bank_with_max_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wpb_in_if.sink    i_in,
    wpb_out_if.source o_out
);
    import wpb_pkg::*;

    // Stage 1: square and ring read data.
    logic    r_s1_vld;
    logic    r_s1_ok;
    t_ch_idx r_s1_ch;
    t_sq     r_s1_sq;

    // Stage 2: updated power of the channel.
    logic    r_s2_vld;
    t_sum    r_s2_pow;

    // Output register.
    logic            r_o_vld;
    t_power          r_o_pow;
    logic [CH_W-1:0] r_o_str;
    logic            r_o_any;

    logic              out_load;
    logic              s2_free;
    logic              s1_adv;
    logic              s1_free;
    logic              accept;
    logic              ch_ok;
    t_ch_idx           ch_idx;
    logic [MAG_W-1:0]  sample_ext;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    t_sq               old_sq;
    t_sum              upd_sum;
    t_sum              sums [CHANNELS];
    t_best             best;
    logic [EXT_W-1:0]  pow_ext;
    t_power            pow_sat;
    t_ring_req         ring_rd;
    t_ring_wr          ring_wr;
    t_sum_upd          sum_upd;

    // Flow control: each stage moves when the one after it is free or moving.
    assign out_load = !r_o_vld || o_out.ready;
    assign s2_free  = !r_s2_vld || out_load;
    assign s1_adv   = r_s1_vld && s2_free;
    assign s1_free  = !r_s1_vld || s2_free;
    assign i_in.ready = s1_free;
    assign accept   = i_in.valid && s1_free;

    // Channel check and exact square of the sample magnitude.
    always_comb begin
        ch_ok      = ({1'b0, i_in.channel} < CH_LIMIT);
        ch_idx     = i_in.channel[CH_IDX_W-1:0];
        sample_ext = {i_in.sample[SAMPLE_W-1], i_in.sample};
        mag        = i_in.sample[SAMPLE_W-1] ? (~sample_ext + MAG_W'(1)) : sample_ext;
        prod       = mag * mag;
    end

    // Ring and sum control.
    always_comb begin
        ring_rd.en     = accept && ch_ok;
        ring_rd.ch     = ch_idx;
        ring_wr.en     = s1_adv && r_s1_ok;
        ring_wr.sq     = r_s1_sq;
        sum_upd.en     = s1_adv && r_s1_ok;
        sum_upd.ch     = r_s1_ch;
        sum_upd.sq     = r_s1_sq;
        sum_upd.old_sq = old_sq;
    end

    wpb_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (ring_rd),
        .i_wr     (ring_wr),
        .o_old_sq (old_sq)
    );

    wpb_sums u_sums (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (sum_upd),
        .o_upd_sum (upd_sum),
        .o_sums    (sums)
    );

    // The sums seen here include exactly the words up to the one in stage 2.
    wpb_max u_max (
        .i_sums (sums),
        .o_best (best)
    );

    // Saturate the channel power to the output width.
    always_comb begin
        pow_ext = EXT_W'(r_s2_pow);
        pow_sat = (pow_ext > EXT_W'(POWER_MAX)) ? POWER_MAX : POWER_W'(pow_ext);
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_vld <= i_in.valid;
            end
            if (s2_free) begin
                r_s2_vld <= r_s1_vld;
            end
            if (out_load) begin
                r_o_vld <= r_s2_vld;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ok <= ch_ok;
            r_s1_ch <= ch_idx;
            r_s1_sq <= prod[SQ_W-1:0];
        end
        if (s1_adv) begin
            r_s2_pow <= r_s1_ok ? upd_sum : '0;
        end
        if (out_load && r_s2_vld) begin
            r_o_pow <= pow_sat;
            r_o_str <= best.idx;
            r_o_any <= best.any;
        end
    end

    assign o_out.valid             = r_o_vld;
    assign o_out.channel_power     = r_o_pow;
    assign o_out.strongest_channel = r_o_str;
    assign o_out.any_power         = r_o_any;

`ifndef SYNTHESIS
    // Input is held off only while stage 1 is occupied.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> r_s1_vld)
        else $error("input stalled with stage 1 empty");

    // A word leaving stage 1 always lands in stage 2.
    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_s2_vld)
        else $error("word lost between stage 1 and stage 2");

    // The reported strongest channel is a real channel.
    a_str_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ({1'b0, o_out.strongest_channel} < CH_LIMIT))
        else $error("strongest channel out of range");

    // With no positive power the strongest channel reads as zero.
    a_no_power: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.any_power) |-> (o_out.strongest_channel == '0))
        else $error("strongest channel nonzero without power");
`endif

endmodule
